FILE: hdl/lsp_pkg.sv
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int MAX_FRAMES = 65536;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int POS_W      = 17;
    localparam int IDX_W      = 16;
    localparam int SAMPLE_W   = 32;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_PLAY  = 3'd2,
        CMD_PAUSE = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_SEEK  = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOADED     = 2'd0,
        REG_LOOP_ON    = 2'd1,
        REG_LOOP_FIRST = 2'd2,
        REG_LOOP_LAST  = 2'd3
    } t_reg_idx;

    // transport result of one transaction, handed to the read stage
    typedef struct packed {
        logic              render;
        logic [ADDR_W-1:0] addr;
        logic              playing;
        logic [POS_W-1:0]  position;
    } t_xport;

endpackage

FILE: hdl/lsp_ram.sv
`timescale 1ns / 1ps

module lsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lsp_transport.sv
`timescale 1ns / 1ps

module lsp_transport (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsp_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_accept,
    input  logic [lsp_pkg::CMD_W-1:0]      i_command,
    input  logic [lsp_pkg::POS_W-1:0]      i_seek_position,
    output lsp_pkg::t_xport                o_xport
);

    localparam int PW = lsp_pkg::POS_W;

    logic [PW-1:0] r_loaded;
    logic          r_loop_on;
    logic [PW-1:0] r_loop_first;
    logic [PW-1:0] r_loop_last;
    logic [PW-1:0] r_cursor;
    logic          r_playing;
    logic [PW-1:0] n_cursor;
    logic          n_playing;

    logic [PW-1:0] w_n;
    logic [PW:0]   w_end0;
    logic [PW:0]   w_end1;
    logic [PW-1:0] w_len;
    logic [PW-1:0] w_start;
    logic          w_can_loop;
    logic [PW-1:0] w_c1;
    logic [PW-1:0] w_c2;
    logic          w_render;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded     <= '0;
            r_loop_on    <= 1'b0;
            r_loop_first <= '0;
            r_loop_last  <= '0;
            r_cursor     <= '0;
            r_playing    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (lsp_pkg::t_reg_idx'(i_cfg_index))
                    lsp_pkg::REG_LOADED:     r_loaded     <= i_cfg_data[PW-1:0];
                    lsp_pkg::REG_LOOP_ON:    r_loop_on    <= i_cfg_data[0];
                    lsp_pkg::REG_LOOP_FIRST: r_loop_first <= i_cfg_data[PW-1:0];
                    lsp_pkg::REG_LOOP_LAST:  r_loop_last  <= i_cfg_data[PW-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_cursor  <= n_cursor;
                r_playing <= n_playing;
            end
        end
    end

    // loop window and tick step
    always_comb begin
        if (32'(r_loaded) > 32'(lsp_pkg::MAX_FRAMES)) begin
            w_n = PW'(lsp_pkg::MAX_FRAMES);
        end else begin
            w_n = r_loaded;
        end
        w_end0 = {1'b0, r_loop_first} + (PW+1)'(1);
        w_end1 = ({1'b0, r_loop_last} > w_end0) ? {1'b0, r_loop_last} : w_end0;
        w_len  = (w_end1 > {1'b0, w_n}) ? w_n : w_end1[PW-1:0];
        w_start    = (r_loop_first < w_len) ? r_loop_first : w_len;
        w_can_loop = r_loop_on && (w_start < w_len);
        w_c1 = (w_can_loop && (r_cursor >= w_len)) ? w_start : r_cursor;
        w_c2 = w_c1 + PW'(1);
    end

    always_comb begin
        n_cursor  = r_cursor;
        n_playing = r_playing;
        w_render  = 1'b0;
        unique case (lsp_pkg::t_cmd'(i_command))
            lsp_pkg::CMD_WRITE: ;
            lsp_pkg::CMD_TICK: begin
                if (r_playing && (w_n != '0)) begin
                    n_cursor = w_c1;
                    if (w_c1 >= w_n) begin
                        n_playing = 1'b0;
                    end else begin
                        w_render  = 1'b1;
                        n_cursor  = w_c2;
                        n_playing = w_can_loop || (w_c2 < w_n);
                    end
                end
            end
            lsp_pkg::CMD_PLAY: begin
                if (w_n != '0) begin
                    if (r_cursor >= w_n) begin
                        n_cursor = '0;
                    end
                    n_playing = 1'b1;
                end
            end
            lsp_pkg::CMD_PAUSE: n_playing = 1'b0;
            lsp_pkg::CMD_STOP: begin
                n_playing = 1'b0;
                n_cursor  = '0;
            end
            lsp_pkg::CMD_SEEK: begin
                n_cursor = ((w_n != '0) && (i_seek_position > w_n)) ? w_n : i_seek_position;
            end
            default: ;
        endcase
        o_xport.render   = w_render;
        o_xport.addr     = lsp_pkg::ADDR_W'(w_c1);
        o_xport.playing  = n_playing;
        o_xport.position = n_cursor;
    end

endmodule

FILE: hdl/looping_sample_player.sv
`timescale 1ns / 1ps

// Stereo looping sample player. Every input transaction (write, tick, play, pause, stop,
// seek) gives exactly one result transaction; one transaction is taken per clock cycle
// while the input is not stalled; its result passes the read stage (the registered read
// of the 64-bit x MAX_FRAMES sample memory, one write and one read port) and the output
// register. Cursor and play state update in the cycle a transaction is taken, so ticks can
// follow each other and a write is visible to the very next tick. The output register plus
// the read stage hold two results, so the input stalls only when both are full and the
// output is stalled. Store entries read before they are written return undefined data.
module looping_sample_player (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lsp_pkg::CMD_W-1:0]         i_command,
    input  logic [lsp_pkg::IDX_W-1:0]         i_frame_index,
    input  logic [lsp_pkg::SAMPLE_W-1:0]      i_left_in,
    input  logic [lsp_pkg::SAMPLE_W-1:0]      i_right_in,
    input  logic [lsp_pkg::POS_W-1:0]         i_seek_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lsp_pkg::SAMPLE_W-1:0]      o_left_out,
    output logic [lsp_pkg::SAMPLE_W-1:0]      o_right_out,
    output logic                              o_frame_valid,
    output logic                              o_playing_now,
    output logic [lsp_pkg::POS_W-1:0]         o_position
);

    localparam int SW = lsp_pkg::SAMPLE_W;

    lsp_pkg::t_xport                   w_xport;
    logic                              w_accept;
    logic                              w_s1_move;
    logic                              w_we;
    logic [lsp_pkg::FRAME_W-1:0]       w_rdata;

    logic                              r_s1_valid;
    logic                              r_s1_render;
    logic                              r_s1_playing;
    logic [lsp_pkg::POS_W-1:0]         r_s1_position;

    logic                              r_out_valid;
    logic [SW-1:0]                     r_out_left;
    logic [SW-1:0]                     r_out_right;
    logic                              r_out_fv;
    logic                              r_out_playing;
    logic [lsp_pkg::POS_W-1:0]         r_out_position;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_we       = w_accept && (lsp_pkg::t_cmd'(i_command) == lsp_pkg::CMD_WRITE)
                        && (32'(i_frame_index) < 32'(lsp_pkg::MAX_FRAMES));

    lsp_transport u_transport (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (w_accept),
        .i_command       (i_command),
        .i_seek_position (i_seek_position),
        .o_xport         (w_xport)
    );

    lsp_ram #(
        .WIDTH (lsp_pkg::FRAME_W),
        .DEPTH (lsp_pkg::MAX_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (lsp_pkg::ADDR_W'(i_frame_index)),
        .i_wdata ({i_right_in, i_left_in}),
        .i_re    (w_accept && w_xport.render),
        .i_raddr (w_xport.addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_render   <= w_xport.render;
            r_s1_playing  <= w_xport.playing;
            r_s1_position <= w_xport.position;
        end
        if (w_s1_move) begin
            r_out_left     <= r_s1_render ? w_rdata[SW-1:0] : '0;
            r_out_right    <= r_s1_render ? w_rdata[2*SW-1:SW] : '0;
            r_out_fv       <= r_s1_render;
            r_out_playing  <= r_s1_playing;
            r_out_position <= r_s1_position;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_out_left;
    assign o_right_out   = r_out_right;
    assign o_frame_valid = r_out_fv;
    assign o_playing_now = r_out_playing;
    assign o_position    = r_out_position;

`ifndef SYNTHESIS
    a_render_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_valid) |-> (o_position != '0))
        else $error("rendered frame with cursor at zero");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_valid) |-> ((o_left_out == '0) && (o_right_out == '0)))
        else $error("nonzero samples without a rendered frame");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can drain");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !o_in_stall) |=> r_s1_valid)
        else $error("accepted transaction lost in read stage");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 58;
    localparam int HOLD_CYCLES   = 150;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [lsp_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [lsp_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [lsp_pkg::SAMPLE_W-1:0] left;
        logic [lsp_pkg::SAMPLE_W-1:0] right;
        logic                         rendered;
        logic                         playing;
        logic [lsp_pkg::POS_W-1:0]    pos;
    } t_player_out;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [lsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lsp_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [lsp_pkg::CMD_W-1:0]     in_cmd = '0;
    logic [lsp_pkg::IDX_W-1:0]     in_idx = '0;
    logic [lsp_pkg::SAMPLE_W-1:0]  in_left = '0;
    logic [lsp_pkg::SAMPLE_W-1:0]  in_right = '0;
    logic [lsp_pkg::POS_W-1:0]     in_seek = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [lsp_pkg::SAMPLE_W-1:0]  out_left;
    logic [lsp_pkg::SAMPLE_W-1:0]  out_right;
    logic                          out_frame_valid;
    logic                          out_playing;
    logic [lsp_pkg::POS_W-1:0]     out_position;

    // player state as predicted
    logic [lsp_pkg::FRAME_W-1:0] frame_mem [lsp_pkg::MAX_FRAMES];
    bit                          frame_written [lsp_pkg::MAX_FRAMES];
    int unsigned                 reg_loaded;
    bit                          reg_loop_on;
    int unsigned                 reg_loop_first;
    int unsigned                 reg_loop_last;
    int unsigned                 play_pos;
    bit                          play_on;

    t_player_out expected_frames [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned focus_lo;
    int unsigned focus_hi;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned failures;
    int unsigned commands_sent;
    int unsigned results_checked;
    int unsigned frames_rendered;
    int unsigned loop_wraps;

    looping_sample_player dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (in_cmd),
        .i_frame_index   (in_idx),
        .i_left_in       (in_left),
        .i_right_in      (in_right),
        .i_seek_position (in_seek),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_left_out      (out_left),
        .o_right_out     (out_right),
        .o_frame_valid   (out_frame_valid),
        .o_playing_now   (out_playing),
        .o_position      (out_position)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned usable_frames();
        return (reg_loaded > lsp_pkg::MAX_FRAMES) ? lsp_pkg::MAX_FRAMES : reg_loaded;
    endfunction

    function automatic void loop_bounds(output int unsigned lo, output int unsigned hi,
                                        output bit wraps);
        int unsigned n;
        n = usable_frames();
        hi = reg_loop_first + 1;
        if (reg_loop_last > hi) hi = reg_loop_last;
        if (hi > n) hi = n;
        lo = (reg_loop_first < hi) ? reg_loop_first : hi;
        wraps = reg_loop_on && (lo < hi);
    endfunction

    // frame address the next tick would render, if any
    function automatic bit tick_source(output int unsigned addr);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        bit          wraps;
        n = usable_frames();
        addr = play_pos;
        if (!play_on || n == 0) return 1'b0;
        loop_bounds(lo, hi, wraps);
        if (wraps && addr >= hi) addr = lo;
        return addr < n;
    endfunction

    function automatic t_player_out apply_command(logic [lsp_pkg::CMD_W-1:0] cmd,
                                                  int unsigned idx,
                                                  logic [lsp_pkg::SAMPLE_W-1:0] left,
                                                  logic [lsp_pkg::SAMPLE_W-1:0] right,
                                                  int unsigned seek);
        t_player_out res;
        int unsigned n;
        int unsigned addr;
        int unsigned lo;
        int unsigned hi;
        bit          wraps;
        res = '0;
        n = usable_frames();
        case (cmd)
            lsp_pkg::CMD_WRITE: begin
                frame_mem[idx] = {right, left};
                frame_written[idx] = 1'b1;
            end
            lsp_pkg::CMD_TICK: begin
                if (tick_source(addr)) begin
                    res.left = frame_mem[addr][lsp_pkg::SAMPLE_W-1:0];
                    res.right = frame_mem[addr][lsp_pkg::FRAME_W-1:lsp_pkg::SAMPLE_W];
                    res.rendered = 1'b1;
                    if (addr != play_pos) loop_wraps++;
                    frames_rendered++;
                    loop_bounds(lo, hi, wraps);
                    play_pos = addr + 1;
                    if (!wraps && play_pos >= n) play_on = 1'b0;
                end else if (n != 0) begin
                    play_on = 1'b0;
                end
            end
            lsp_pkg::CMD_PLAY: begin
                if (n != 0) begin
                    if (play_pos >= n) play_pos = 0;
                    play_on = 1'b1;
                end
            end
            lsp_pkg::CMD_PAUSE: begin
                play_on = 1'b0;
            end
            lsp_pkg::CMD_STOP: begin
                play_on = 1'b0;
                play_pos = 0;
            end
            lsp_pkg::CMD_SEEK: begin
                play_pos = (n != 0 && seek > n) ? n : seek;
            end
            default: begin
            end
        endcase
        res.playing = play_on;
        res.pos = play_pos[lsp_pkg::POS_W-1:0];
        return res;
    endfunction

    task automatic send_cmd(logic [lsp_pkg::CMD_W-1:0] cmd, int unsigned idx,
                            logic [lsp_pkg::SAMPLE_W-1:0] left,
                            logic [lsp_pkg::SAMPLE_W-1:0] right, int unsigned seek);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_idx <= idx[lsp_pkg::IDX_W-1:0];
        in_left <= left;
        in_right <= right;
        in_seek <= seek[lsp_pkg::POS_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_frames.push_back(apply_command(cmd, idx[lsp_pkg::IDX_W-1:0], left, right,
                                                seek[lsp_pkg::POS_W-1:0]));
        commands_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(lsp_pkg::t_reg_idx which, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value[lsp_pkg::CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic program_regs(int unsigned loaded, bit lp, int unsigned first,
                                int unsigned last);
        write_reg(lsp_pkg::REG_LOADED, loaded);
        write_reg(lsp_pkg::REG_LOOP_ON, lp);
        write_reg(lsp_pkg::REG_LOOP_FIRST, first);
        write_reg(lsp_pkg::REG_LOOP_LAST, last);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_loaded = loaded & 17'h1FFFF;
        reg_loop_on = lp;
        reg_loop_first = first & 17'h1FFFF;
        reg_loop_last = last & 17'h1FFFF;
    endtask

    task automatic begin_phase(int unsigned loaded, bit lp, int unsigned first,
                               int unsigned last, int unsigned send_pct, int unsigned recv_pct,
                               int unsigned lo, int unsigned hi);
        settle();
        program_regs(loaded, lp, first, last);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        focus_lo = lo;
        focus_hi = hi;
    endtask

    task automatic issue_random_command();
        int unsigned pick;
        int unsigned addr;
        int unsigned idx;
        int unsigned seek;
        pick = $urandom_range(99);
        idx = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                        : $urandom_range(focus_hi, focus_lo);
        seek = ($urandom_range(3) == 0) ? $urandom_range(17'h1FFFF)
                                         : $urandom_range(focus_hi + 1, focus_lo);
        if (pick < 45) begin
            // never render a store entry that was not written yet
            if (tick_source(addr) && !frame_written[addr])
                send_cmd(lsp_pkg::CMD_WRITE, addr, $urandom, $urandom, seek);
            send_cmd(lsp_pkg::CMD_TICK, idx, $urandom, $urandom, seek);
        end else if (pick < 60) begin
            send_cmd(lsp_pkg::CMD_WRITE, idx, $urandom, $urandom, seek);
        end else if (pick < 71) begin
            send_cmd(lsp_pkg::CMD_PLAY, idx, $urandom, $urandom, seek);
        end else if (pick < 77) begin
            send_cmd(lsp_pkg::CMD_PAUSE, idx, $urandom, $urandom, seek);
        end else if (pick < 81) begin
            send_cmd(lsp_pkg::CMD_STOP, idx, $urandom, $urandom, seek);
        end else if (pick < 95) begin
            send_cmd(lsp_pkg::CMD_SEEK, idx, $urandom, $urandom, seek);
        end else begin
            send_cmd($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, idx, $urandom, $urandom,
                     seek);
        end
    endtask

    task automatic run_random(int count);
        repeat (count) issue_random_command();
    endtask

    task automatic test_empty_player();
        send_cmd(lsp_pkg::CMD_TICK, 0, '0, '0, 0);
        send_cmd(lsp_pkg::CMD_PLAY, 0, '0, '0, 0);
        send_cmd(lsp_pkg::CMD_SEEK, 0, '0, '0, 17'h1FFFF);
        send_cmd(CMD_SPARE_6, 16'hFFFF, '1, '1, 17'h1FFFF);
        send_cmd(CMD_SPARE_7, 0, '0, '0, 0);
    endtask

    task automatic test_linear_playback();
        begin_phase(4, 1'b0, 0, 0, 0, 0, 0, 3);
        send_cmd(lsp_pkg::CMD_WRITE, 0, 32'h0000_0000, 32'h0000_0000, 0);
        send_cmd(lsp_pkg::CMD_WRITE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_cmd(lsp_pkg::CMD_WRITE, 2, 32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_cmd(lsp_pkg::CMD_WRITE, 3, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_cmd(lsp_pkg::CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_cmd(lsp_pkg::CMD_SEEK, 0, '0, '0, 17'h1FFFF);
        send_cmd(lsp_pkg::CMD_PLAY, 0, '0, '0, 0);
        repeat (5) send_cmd(lsp_pkg::CMD_TICK, 0, '0, '0, 0);
    endtask

    task automatic test_loop_wrap();
        begin_phase(4, 1'b1, 1, 3, 0, 0, 0, 3);
        send_cmd(lsp_pkg::CMD_PLAY, 0, '0, '0, 0);
        repeat (4) send_cmd(lsp_pkg::CMD_TICK, 0, '0, '0, 0);
        send_cmd(lsp_pkg::CMD_PAUSE, 0, '0, '0, 0);
        send_cmd(lsp_pkg::CMD_TICK, 0, '0, '0, 0);
        send_cmd(lsp_pkg::CMD_SEEK, 0, '0, '0, 2);
        send_cmd(lsp_pkg::CMD_STOP, 0, '0, '0, 0);
    endtask

    task automatic test_looped_region();
        begin_phase(16, 1'b1, 4, 12, 0, 0, 0, 15);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_one_shot_playback();
        begin_phase(24, 1'b0, 0, 0, 49, 0, 0, 23);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_single_frame_loop();
        begin_phase(1, 1'b1, 0, 0, 0, 49, 0, 1);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_loop_end_below_start();
        begin_phase(40, 1'b1, 30, 10, 15, 15, 0, 39);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_loop_start_past_length();
        begin_phase(20, 1'b1, 17'h1FFFF, 100, 0, 0, 0, 19);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_oversized_length();
        begin_phase(17'h1FFFF, 1'b1, 65530, 17'h1FFFF, 49, 0, 65528, 65535);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_unloaded_seek();
        begin_phase(0, 1'b1, 3, 7, 49, 49, 0, 15);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_full_store_tail();
        begin_phase(lsp_pkg::MAX_FRAMES, 1'b0, 0, lsp_pkg::MAX_FRAMES, 15, 15, 65530, 65535);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_output_backpressure();
        begin_phase(12, 1'b1, 2, 9, 0, 0, 0, 11);
        @(negedge clk);
        hold_request = HOLD_CYCLES;
        @(posedge clk);
        run_random(PHASE_ITEMS);
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_player_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                if (failures < REPORT_LIMIT)
                    $display("unexpected result transaction: L=%h R=%h fv=%b play=%b pos=%0d",
                             out_left, out_right, out_frame_valid, out_playing, out_position);
                failures++;
            end else begin
                want = expected_frames.pop_front();
                results_checked++;
                if (out_left !== want.left || out_right !== want.right
                        || out_frame_valid !== want.rendered || out_playing !== want.playing
                        || out_position !== want.pos) begin
                    if (failures < REPORT_LIMIT)
                        $display({"mismatch on result %0d: expected L=%h R=%h fv=%b play=%b",
                                  " pos=%0d, got L=%h R=%h fv=%b play=%b pos=%0d"},
                                 results_checked, want.left, want.right, want.rendered,
                                 want.playing, want.pos, out_left, out_right,
                                 out_frame_valid, out_playing, out_position);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_frames.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_player();
        test_linear_playback();
        test_loop_wrap();
        test_looped_region();
        test_one_shot_playback();
        test_single_frame_loop();
        test_loop_end_below_start();
        test_loop_start_past_length();
        test_oversized_length();
        test_unloaded_seek();
        test_full_store_tail();
        test_output_backpressure();
        settle();
        $display("%0d commands sent, %0d results checked, %0d frames rendered, %0d loop wraps",
                 commands_sent, results_checked, frames_rendered, loop_wraps);
        $display("loop settings from empty store to oversized length, idle/stall mixes, hold-off");
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
